// ===== rtl/core/kmb_pkg.sv =====
// shared types, constants and helper functions of the keystroke macro buffer
`default_nettype none

package kmb_pkg;

  // default store depth in key codes
  localparam int KMB_STORE_DEPTH = 64;

  // field widths
  localparam int KMB_OP_W        = 3;
  localparam int KMB_VALUE_W     = 16;
  localparam int KMB_KEY_W       = 8;
  localparam int KMB_IN_TDATA_W  = 24;
  localparam int KMB_CFG_IDX_W   = 1;

  // decimal conversion of a value word
  localparam int KMB_DIGITS      = 5;
  localparam int KMB_DIGIT_W     = 4;
  localparam int KMB_BCD_W       = KMB_DIGITS * KMB_DIGIT_W;
  localparam int KMB_DIGIT_CNT_W = $clog2(KMB_DIGITS + 1);

  // operation codes
  typedef logic [KMB_OP_W-1:0] op_t;
  localparam op_t OP_BEGIN      = 3'd0;
  localparam op_t OP_PEEK       = 3'd1;
  localparam op_t OP_GET        = 3'd2;
  localparam op_t OP_PUT_BYTE   = 3'd3;
  localparam op_t OP_PUT_NUMBER = 3'd4;

  // configuration register indexes
  typedef logic [KMB_CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DIGIT_ZERO_KEY = 1'd0;
  localparam cfg_idx_t CFG_DIGIT_ONE_KEY  = 1'd1;

  // configuration reset values
  localparam logic [KMB_KEY_W-1:0] DIGIT_ZERO_KEY_RST = 8'd39;
  localparam logic [KMB_KEY_W-1:0] DIGIT_ONE_KEY_RST  = 8'd30;

  // control sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_EMIT = 5'b00100,
    ST_TERM = 5'b01000,
    ST_READ = 5'b10000
  } state_t;

  // key code of one decimal digit
  function automatic logic [KMB_KEY_W-1:0] digit_key(
    input logic [KMB_DIGIT_W-1:0] d,
    input logic [KMB_KEY_W-1:0]   zero_key,
    input logic [KMB_KEY_W-1:0]   one_key
  );
    logic [KMB_KEY_W-1:0] k;
    if (d == '0) begin
      k = zero_key;
    end else begin
      k = one_key + {{(KMB_KEY_W-KMB_DIGIT_W){1'b0}}, d} - 8'd1;
    end
    return k;
  endfunction

  // add three to every decimal digit of five or more
  function automatic logic [KMB_BCD_W-1:0] bcd_adjust(input logic [KMB_BCD_W-1:0] bcd);
    logic [KMB_BCD_W-1:0] r;
    r = bcd;
    for (int i = 0; i < KMB_DIGITS; i++) begin
      if (bcd[i*KMB_DIGIT_W +: KMB_DIGIT_W] >= 4'd5) begin
        r[i*KMB_DIGIT_W +: KMB_DIGIT_W] = bcd[i*KMB_DIGIT_W +: KMB_DIGIT_W] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kmb_ram.sv =====
// generic single-port ram with registered read
`default_nettype none

module kmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first access
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/kmb_bin2bcd.sv =====
// bit-serial binary to decimal converter (shift and add three)
`default_nettype none

module kmb_bin2bcd
  import kmb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [KMB_VALUE_W-1:0] bin,
  output logic                        done,
  output logic      [KMB_BCD_W-1:0]   bcd
);

  localparam int CNT_W = $clog2(KMB_VALUE_W);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [KMB_VALUE_W-1:0] bin_r, bin_nxt;
  logic [KMB_BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [KMB_BCD_W-1:0]   bcd_adj;

  // one binary bit enters the digit register per cycle
  always_comb begin
    bcd_adj  = bcd_adjust(bcd_r);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(KMB_VALUE_W - 1);
      bin_nxt  = bin;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = {bcd_adj[KMB_BCD_W-2:0], bin_r[KMB_VALUE_W-1]};
      bin_nxt = {bin_r[KMB_VALUE_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

`default_nettype wire

// ===== rtl/core/keystroke_macro_buffer.sv =====
// top level of the keystroke macro buffer
`default_nettype none

// Keystroke macro buffer: a store of STORE_DEPTH key codes with one shared
// position and a replay limit. Words on the input stream carry an operation
// and a value; peek and get answer with one key word on the output stream,
// the other operations give none. Items are taken one at a time. Begin is
// handled on acceptance; peek and get make one registered read of the key
// store and then wait for the output register to drain; put byte writes the
// key, then the terminator. Put number runs the bit-serial binary to decimal
// conversion, hands over the digits, then makes one store write or
// leading-zero skip per decimal digit (five) and writes the terminator. The
// store needs no clearing pass after reset: a fill count marks the written
// prefix, and entries beyond it read as zero.

module keystroke_macro_buffer
  import kmb_pkg::*;
#(
  parameter int STORE_DEPTH = KMB_STORE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input stream
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [KMB_IN_TDATA_W-1:0] in_tdata,   // [2:0] operation, [18:3] value
  // result stream
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic      [KMB_KEY_W-1:0]      out_tdata,  // [7:0] key
  // configuration write port
  input  wire logic                      cfg_we,
  input  wire logic [KMB_CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [KMB_KEY_W-1:0]      cfg_wdata
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  // input word fields
  op_t                    in_op;
  logic [KMB_VALUE_W-1:0] in_value;
  logic                   in_fire;

  assign in_op    = in_tdata[KMB_OP_W-1:0];
  assign in_value = in_tdata[KMB_OP_W +: KMB_VALUE_W];

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              pos_r, pos_nxt;
  logic [CW-1:0]              limit_r, limit_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic [KMB_KEY_W-1:0]       zero_key_r, zero_key_nxt;
  logic [KMB_KEY_W-1:0]       one_key_r, one_key_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [KMB_KEY_W-1:0]       out_key_r, out_key_nxt;
  logic [KMB_BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [KMB_DIGIT_CNT_W-1:0] emit_cnt_r, emit_cnt_nxt;
  logic                       started_r, started_nxt;
  logic                       byte_mode_r, byte_mode_nxt;
  logic [KMB_KEY_W-1:0]       byte_r, byte_nxt;
  logic                       hit_r, hit_nxt;
  logic                       get_r, get_nxt;

  // store port and converter hookup
  logic                   ram_we;
  logic [KMB_KEY_W-1:0]   ram_wdata;
  logic [KMB_KEY_W-1:0]   ram_rdata;
  logic                   conv_start;
  logic                   conv_done;
  logic [KMB_BCD_W-1:0]   conv_bcd;
  logic [KMB_DIGIT_W-1:0] top_digit;
  logic                   do_write;
  logic                   room;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign top_digit = bcd_r[KMB_BCD_W-1 -: KMB_DIGIT_W];
  assign room      = (pos_r < DEPTH_C);
  assign do_write  = byte_mode_r || started_r || (top_digit != '0) ||
                     (emit_cnt_r == KMB_DIGIT_CNT_W'(1));

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    limit_nxt     = limit_r;
    fill_nxt      = fill_r;
    zero_key_nxt  = zero_key_r;
    one_key_nxt   = one_key_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    bcd_nxt       = bcd_r;
    emit_cnt_nxt  = emit_cnt_r;
    started_nxt   = started_r;
    byte_mode_nxt = byte_mode_r;
    byte_nxt      = byte_r;
    hit_nxt       = hit_r;
    get_nxt       = get_r;
    ram_we        = 1'b0;
    ram_wdata     = '0;
    conv_start    = 1'b0;

    // configuration writes
    if (cfg_we) begin
      case (cfg_addr)
        CFG_DIGIT_ZERO_KEY: zero_key_nxt = cfg_wdata;
        CFG_DIGIT_ONE_KEY:  one_key_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    // result word taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_BEGIN: begin
              pos_nxt   = '0;
              limit_nxt = (in_value > KMB_VALUE_W'(STORE_DEPTH)) ? DEPTH_C : CW'(in_value);
            end
            OP_PEEK, OP_GET: begin
              hit_nxt   = (pos_r < limit_r) && (pos_r < fill_r);
              get_nxt   = (in_op == OP_GET);
              state_nxt = ST_READ;
            end
            OP_PUT_BYTE: begin
              byte_nxt      = in_value[KMB_KEY_W-1:0];
              byte_mode_nxt = 1'b1;
              started_nxt   = 1'b1;
              emit_cnt_nxt  = KMB_DIGIT_CNT_W'(1);
              state_nxt     = ST_EMIT;
            end
            OP_PUT_NUMBER: begin
              conv_start = 1'b1;
              state_nxt  = ST_CONV;
            end
            default: ;
          endcase
        end
      end

      // wait for the decimal digits
      ST_CONV: begin
        if (conv_done) begin
          bcd_nxt       = conv_bcd;
          emit_cnt_nxt  = KMB_DIGIT_CNT_W'(KMB_DIGITS);
          started_nxt   = 1'b0;
          byte_mode_nxt = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end

      // one key per cycle, leading zero digits skipped
      ST_EMIT: begin
        if (do_write) begin
          started_nxt = 1'b1;
          if (room) begin
            ram_we    = 1'b1;
            ram_wdata = byte_mode_r ? byte_r : digit_key(top_digit, zero_key_r, one_key_r);
            pos_nxt   = pos_r + 1'b1;
            if (pos_r == fill_r) begin
              fill_nxt = fill_r + 1'b1;
            end
          end
        end
        bcd_nxt      = {bcd_r[KMB_BCD_W-KMB_DIGIT_W-1:0], {KMB_DIGIT_W{1'b0}}};
        emit_cnt_nxt = emit_cnt_r - 1'b1;
        if (emit_cnt_r == KMB_DIGIT_CNT_W'(1)) begin
          state_nxt = ST_TERM;
        end
      end

      // zero terminator after the last key
      ST_TERM: begin
        if (room) begin
          ram_we    = 1'b1;
          ram_wdata = '0;
          if (pos_r == fill_r) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
        state_nxt = ST_IDLE;
      end

      // store data is ready, hand out the key once the output is free
      ST_READ: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = hit_r ? ram_rdata : '0;
          if (get_r) begin
            if (hit_r && (ram_rdata != '0)) begin
              pos_nxt = pos_r + 1'b1;
            end else begin
              pos_nxt   = '0;
              limit_nxt = '0;
            end
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      limit_r     <= '0;
      fill_r      <= '0;
      zero_key_r  <= DIGIT_ZERO_KEY_RST;
      one_key_r   <= DIGIT_ONE_KEY_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      limit_r     <= limit_nxt;
      fill_r      <= fill_nxt;
      zero_key_r  <= zero_key_nxt;
      one_key_r   <= one_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_key_r   <= out_key_nxt;
    bcd_r       <= bcd_nxt;
    emit_cnt_r  <= emit_cnt_nxt;
    started_r   <= started_nxt;
    byte_mode_r <= byte_mode_nxt;
    byte_r      <= byte_nxt;
    hit_r       <= hit_nxt;
    get_r       <= get_nxt;
  end

  // decimal converter
  kmb_bin2bcd u_bin2bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .bin   (in_value),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // key store
  kmb_ram #(
    .WIDTH (KMB_KEY_W),
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_key_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (pos_r[AW-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_key_r;

endmodule

`default_nettype wire

// ===== test/keystroke_macro_buffer_tb.sv =====
// self-checking testbench of the keystroke macro buffer
`default_nettype none

module keystroke_macro_buffer_tb;
  import kmb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH  = KMB_STORE_DEPTH;
  localparam int ITEM_COUNT   = 1400;
  localparam int PHASE_COUNT  = 6;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int REPORT_LINES = 50;

  // operation codes the block leaves unused
  localparam op_t OP_FIRST_UNUSED = 3'd5;
  localparam op_t OP_LAST_UNUSED  = 3'd7;

  // tracks the macro store and holds the key words still to come
  class keystroke_scoreboard;
    logic [KMB_KEY_W-1:0] keys [STORE_DEPTH];
    int unsigned          pos;
    int unsigned          lim;
    logic [KMB_KEY_W-1:0] zero_key;
    logic [KMB_KEY_W-1:0] one_key;
    logic [KMB_KEY_W-1:0] expected_keys [$];
    int                   errors;

    function new();
      foreach (keys[i]) keys[i] = '0;
      pos      = 0;
      lim      = 0;
      zero_key = DIGIT_ZERO_KEY_RST;
      one_key  = DIGIT_ONE_KEY_RST;
      errors   = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [KMB_KEY_W-1:0] v);
      if (idx == CFG_DIGIT_ZERO_KEY) begin
        zero_key = v;
      end else if (idx == CFG_DIGIT_ONE_KEY) begin
        one_key = v;
      end
    endfunction

    function int pending();
      return expected_keys.size();
    endfunction

    // append one key and a terminator behind it while there is room
    function void store_key(logic [KMB_KEY_W-1:0] k);
      if (pos < STORE_DEPTH) begin
        keys[pos] = k;
        pos++;
        if (pos < STORE_DEPTH) begin
          keys[pos] = '0;
        end
      end
    endfunction

    function logic [KMB_KEY_W-1:0] digit_code(int unsigned d);
      logic [KMB_KEY_W-1:0] k;
      if (d == 0) begin
        k = zero_key;
      end else begin
        k = one_key + KMB_KEY_W'(d) - 8'd1;
      end
      return k;
    endfunction

    // decimal digits, most significant first, no leading zeros
    function void store_number(logic [KMB_VALUE_W-1:0] v);
      int unsigned n;
      int unsigned scale;
      int unsigned d;
      bit          started;
      n       = v;
      started = 1'b0;
      for (scale = 10000; scale > 0; scale = scale / 10) begin
        d = n / scale;
        if (d != 0 || scale == 1 || started) begin
          started = 1'b1;
          store_key(digit_code(d));
        end
        n = n % scale;
      end
    endfunction

    // predict the effect of one accepted input word
    function void note_word(op_t op, logic [KMB_VALUE_W-1:0] v);
      case (op)
        OP_BEGIN: begin
          pos = 0;
          lim = (v > STORE_DEPTH) ? STORE_DEPTH : v;
        end
        OP_PEEK: begin
          expected_keys.push_back((pos < lim && pos < STORE_DEPTH) ? keys[pos] : '0);
        end
        OP_GET: begin
          // a zero key or the limit ends the replay
          if (pos < lim && pos < STORE_DEPTH && keys[pos] != '0) begin
            expected_keys.push_back(keys[pos]);
            pos++;
          end else begin
            pos = 0;
            lim = 0;
            expected_keys.push_back('0);
          end
        end
        OP_PUT_BYTE: begin
          store_key(v[KMB_KEY_W-1:0]);
        end
        OP_PUT_NUMBER: begin
          store_number(v);
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what);
      if (errors < REPORT_LINES) begin
        $display("mismatch: %s", what);
      end
      errors++;
    endtask

    // compare one accepted result word with the oldest prediction
    task check_key(logic [KMB_KEY_W-1:0] k);
      logic [KMB_KEY_W-1:0] want;
      if (expected_keys.size() == 0) begin
        report($sformatf("key %02h arrived with no prediction waiting", k));
      end else begin
        want = expected_keys.pop_front();
        if (k !== want) begin
          report($sformatf("key %02h, predicted %02h", k, want));
        end
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [KMB_IN_TDATA_W-1:0] in_tdata;   // [2:0] operation, [18:3] value
  logic                      out_tvalid;
  logic                      out_tready;
  logic [KMB_KEY_W-1:0]      out_tdata;  // [7:0] key
  logic                      cfg_we;
  logic [KMB_CFG_IDX_W-1:0]  cfg_addr;
  logic [KMB_KEY_W-1:0]      cfg_wdata;

  keystroke_scoreboard sb;
  int                  items_sent;
  int                  burst_left;
  int                  cycle_count;
  int                  ready_mode;
  int                  ready_mode_left;
  int                  ready_hold;

  keystroke_macro_buffer #(
    .STORE_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // known values on every input from time zero
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    sb         = new();
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL keystroke_macro_buffer");
      $finish;
    end
  end

  // receiver back-pressure: always ready, coin flips, or long stalls
  always @(posedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode      = $urandom_range(0, 2);
      ready_mode_left = $urandom_range(50, 300);
    end else begin
      ready_mode_left--;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (ready_hold == 0) begin
          out_tready <= ~out_tready;
          ready_hold = $urandom_range(0, 12);
        end else begin
          ready_hold--;
        end
      end
    endcase
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_word(op_t'(in_tdata[2:0]), in_tdata[18:3]);
      end
      if (out_tvalid && out_tready) begin
        sb.check_key(out_tdata);
      end
    end
  end

  // send one word, pausing between bursts
  task automatic send_word(op_t op, logic [KMB_VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, v, op};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (op <= OP_PUT_NUMBER) begin
      items_sent++;
    end
  endtask

  // stop sending and let the block run dry
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write both digit registers back to back
  task automatic configure(logic [KMB_KEY_W-1:0] zero_key, logic [KMB_KEY_W-1:0] one_key);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DIGIT_ZERO_KEY;
    cfg_wdata <= zero_key;
    @(posedge clk);
    sb.set_register(CFG_DIGIT_ZERO_KEY, zero_key);
    cfg_addr  <= CFG_DIGIT_ONE_KEY;
    cfg_wdata <= one_key;
    @(posedge clk);
    sb.set_register(CFG_DIGIT_ONE_KEY, one_key);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_noise();
    send_word(op_t'($urandom_range(0, OP_LAST_UNUSED)), 16'($urandom_range(0, 65535)));
  endtask

  // number with a random count of decimal digits
  function automatic logic [KMB_VALUE_W-1:0] random_number();
    logic [KMB_VALUE_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = 16'($urandom_range(0, 9));
      1: v = 16'($urandom_range(10, 99));
      2: v = 16'($urandom_range(100, 999));
      3: v = 16'($urandom_range(1000, 9999));
      default: v = 16'($urandom_range(10000, 65535));
    endcase
    return v;
  endfunction

  function automatic logic [KMB_VALUE_W-1:0] random_limit();
    logic [KMB_VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'($urandom_range(0, 8));
      1: v = 16'($urandom_range(8, STORE_DEPTH));
      2: v = 16'($urandom_range(STORE_DEPTH + 1, 65535));
      default: v = 16'($urandom_range(1, 24));
    endcase
    return v;
  endfunction

  task automatic send_put();
    logic [KMB_KEY_W-1:0] k;
    if ($urandom_range(0, 1) == 0) begin
      k = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_word(OP_PUT_BYTE, {8'($urandom_range(0, 255)), k});
    end else begin
      send_word(OP_PUT_NUMBER, random_number());
    end
  endtask

  // record a macro, then replay part or all of it
  task automatic run_macro();
    int rec_len;
    int play_len;
    int i;
    rec_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 10);
    play_len = $urandom_range(1, 30);
    if ($urandom_range(0, 3) != 0) begin
      send_word(OP_BEGIN, random_limit());
    end
    for (i = 0; i < rec_len; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_noise();
      end else begin
        send_put();
      end
    end
    send_word(OP_BEGIN, random_limit());
    for (i = 0; i < play_len; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_noise();
      end else if ($urandom_range(0, 3) == 0) begin
        send_word(OP_PEEK, 16'($urandom_range(0, 65535)));
      end else begin
        send_word(OP_GET, 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  // main sequence
  initial begin
    int phase;
    int i;
    logic [KMB_KEY_W-1:0] phase_zero;
    logic [KMB_KEY_W-1:0] phase_one;
    items_sent      = 0;
    burst_left      = 0;
    cycle_count     = 0;
    ready_mode      = 0;
    ready_mode_left = 0;
    ready_hold      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words with the reset digit codes
    send_word(OP_GET, 16'hFFFF);
    send_word(OP_FIRST_UNUSED, 16'hFFFF);
    send_word(OP_LAST_UNUSED, 16'h0000);
    send_word(OP_PUT_BYTE, 16'hFF5A);
    send_word(OP_PUT_NUMBER, 16'd0);
    send_word(OP_PUT_NUMBER, 16'd10000);
    send_word(OP_BEGIN, 16'hFFFF);
    send_word(OP_PEEK, 16'h0000);
    send_word(OP_GET, 16'h0000);
    // walk to the terminator
    for (i = 0; i < 7; i++) begin
      send_word(OP_GET, 16'h0000);
    end
    // write twelve five-digit numbers into the store, then one byte
    for (i = 0; i < 12; i++) begin
      send_word(OP_PUT_NUMBER, 16'hFFFF);
    end
    send_word(OP_PUT_BYTE, 16'h00FF);
    send_word(OP_BEGIN, 16'd1);
    send_word(OP_GET, 16'h0000);
    send_word(OP_GET, 16'h0000);
    send_word(OP_PEEK, 16'h0000);
    settle();

    // random phases, each with its own digit codes
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin phase_zero = 8'h00; phase_one = 8'h00; end
        1: begin phase_zero = 8'hFF; phase_one = 8'hFF; end
        2: begin phase_zero = DIGIT_ZERO_KEY_RST; phase_one = DIGIT_ONE_KEY_RST; end
        4: begin phase_zero = 8'hFF; phase_one = 8'h00; end
        default: begin
          phase_zero = 8'($urandom_range(0, 255));
          phase_one  = 8'($urandom_range(0, 255));
        end
      endcase
      configure(phase_zero, phase_one);
      @(posedge clk);
      while (items_sent < (phase + 1) * ITEM_COUNT / PHASE_COUNT) begin
        run_macro();
      end
      settle();
    end

    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d predicted keys never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("PASS keystroke_macro_buffer");
    end else begin
      $display("FAIL keystroke_macro_buffer");
    end
    $finish;
  end

endmodule

`default_nettype wire
